>>> hw/rtl/rmvmm_pkg.sv
// rmvmm_pkg: widths, microcode word layout and control store for the running statistics block
package rmvmm_pkg;

  // sample and fixed point formats
  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 16;
  localparam int COUNT_W    = 32;
  localparam int MEAN_W     = SAMPLE_W + FRAC_W;
  localparam int DEV_W      = 64;
  localparam int PROD_SHIFT = 2 * FRAC_W - 8;

  // multiplier split: mean-wide magnitude times half of the other magnitude
  localparam int MUL_LO_W   = MEAN_W / 2;
  localparam int MUL_B_W    = MEAN_W - MUL_LO_W;
  localparam int PART_W     = MEAN_W + MUL_B_W;
  localparam int PROD_W     = 2 * MEAN_W;
  localparam int TERM_W     = PROD_W - PROD_SHIFT;

  // divider step counter
  localparam int DIV_CNT_W  = $clog2(MEAN_W);

  // sequencer program counter
  localparam int PC_W = 4;

  // jump and hold conditions
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_FULL     = 3'd3,
    COND_DIV_MORE = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_t;

  // one control word per microcode step
  typedef struct packed {
    logic            in_rdy;
    logic            init;
    logic            div_step;
    logic            mean_upd;
    logic            dev2;
    logic            mul_lo;
    logic            mul_hi;
    logic            commit;
    logic            emit;
    cond_t           hold;
    cond_t           jmp;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic accept;
    logic full;
    logic div_more;
    logic out_busy;
  } seq_stat_t;

  // step addresses
  localparam logic [PC_W-1:0] ST_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] ST_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] ST_DIV    = 4'd2;
  localparam logic [PC_W-1:0] ST_MEAN   = 4'd3;
  localparam logic [PC_W-1:0] ST_DEV2   = 4'd4;
  localparam logic [PC_W-1:0] ST_MUL_LO = 4'd5;
  localparam logic [PC_W-1:0] ST_MUL_HI = 4'd6;
  localparam logic [PC_W-1:0] ST_COMMIT = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT   = 4'd8;

  // control store
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_word_t w;
    w        = '0;
    w.hold   = COND_NEVER;
    w.jmp    = COND_NEVER;
    w.target = ST_WAIT;
    case (addr)
      ST_WAIT: begin
        w.in_rdy = 1'b1;
        w.hold   = COND_NO_INPUT;
      end
      ST_CHECK: begin
        w.init   = 1'b1;
        w.jmp    = COND_FULL;
        w.target = ST_EMIT;
      end
      ST_DIV: begin
        w.div_step = 1'b1;
        w.hold     = COND_DIV_MORE;
      end
      ST_MEAN:   w.mean_upd = 1'b1;
      ST_DEV2:   w.dev2     = 1'b1;
      ST_MUL_LO: w.mul_lo   = 1'b1;
      ST_MUL_HI: w.mul_hi   = 1'b1;
      ST_COMMIT: w.commit   = 1'b1;
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.hold   = COND_OUT_BUSY;
        w.jmp    = COND_ALWAYS;
        w.target = ST_WAIT;
      end
      default: begin
        w.jmp    = COND_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rmvmm_in_if.sv
// rmvmm_in_if: sample channel carrying one wait-time word
interface rmvmm_in_if import rmvmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_us;

  modport source (output valid, output sample_us, input ready);
  modport sink   (input valid, input sample_us, output ready);
endinterface

>>> hw/rtl/rmvmm_out_if.sv
// rmvmm_out_if: result channel carrying the running statistics word
interface rmvmm_out_if import rmvmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  sample_count;
  logic [MEAN_W-1:0]   mean_value;
  logic [DEV_W-1:0]    squared_dev_sum;
  logic [SAMPLE_W-1:0] min_sample;
  logic [SAMPLE_W-1:0] max_sample;
  logic                overflow;

  modport source (output valid, output sample_count, output mean_value,
                  output squared_dev_sum, output min_sample, output max_sample,
                  output overflow, input ready);
  modport sink   (input valid, input sample_count, input mean_value,
                  input squared_dev_sum, input min_sample, input max_sample,
                  input overflow, output ready);
endinterface

>>> hw/rtl/running_mean_variance_min_max.sv
// running_mean_variance_min_max: top level, Welford running statistics datapath
//
//   channel  | dir | payload                                             | handshake
//   in_ch    | in  | sample_us                                           | valid/ready
//   out_ch   | out | sample_count mean_value squared_dev_sum min/max ovf | valid/ready
//
// From acceptance to the result register a word passes through one check step,
// 40 steps of the restoring divider (one quotient bit a step), mean and deviation
// steps, two multiply steps of a 40x20 multiplier, commit and result load.
// The wait step follows, so a new sample is accepted only once the previous one is through.
// A saturated counter jumps from the check step to result load, skipping divider, update and commit.
// rst_n is synchronous; it clears the statistics and the sequencer, min to all ones.
// The next sample is taken while the previous result still waits in the output register;
// the result load step holds while that register is full and not being drained.
module running_mean_variance_min_max import rmvmm_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  rmvmm_in_if.sink     in_ch,
  rmvmm_out_if.source  out_ch
);

  ctrl_word_t cw;
  seq_stat_t  stat;

  // statistics state
  logic [COUNT_W-1:0]  count_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [DEV_W-1:0]    devsum_r;
  logic [SAMPLE_W-1:0] min_r, max_r;

  // per-sample working registers
  logic [SAMPLE_W-1:0]  x_r;
  logic                 ovf_r;
  logic                 neg1_r;
  logic [MEAN_W-1:0]    mag1_r;
  logic [COUNT_W-1:0]   rem_r;
  logic [MEAN_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [MEAN_W-1:0]    mean_new_r;
  logic [MEAN_W-1:0]    mag2_r;
  logic                 skip_r;
  logic [PROD_W-1:0]    acc_r;

  // result register
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [MEAN_W-1:0]   out_mean_r;
  logic [DEV_W-1:0]    out_dev_r;
  logic [SAMPLE_W-1:0] out_min_r, out_max_r;
  logic                out_ovf_r;

  logic [MEAN_W-1:0]  xs;
  logic               full;
  logic [COUNT_W-1:0] divisor;
  logic               neg1;
  logic [MEAN_W-1:0]  mag1;
  logic [COUNT_W:0]   rem_sh;
  logic               ge;
  logic [COUNT_W:0]   rem_sub;
  logic [MEAN_W-1:0]  mean_new;
  logic               neg2;
  logic [MEAN_W-1:0]  mag2;
  logic [MUL_B_W-1:0] mul_b;
  logic [PART_W-1:0]  part;
  logic [TERM_W-1:0]  term;
  logic [DEV_W:0]     dev_sum;
  logic               out_busy;

  rmvmm_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  // handshake and sequencer status
  assign in_ch.ready   = cw.in_rdy && rst_n;
  assign full          = (count_r == {COUNT_W{1'b1}});
  assign out_busy      = out_valid_r && !out_ch.ready;
  assign stat.accept   = in_ch.valid && in_ch.ready;
  assign stat.full     = full;
  assign stat.div_more = (div_cnt_r != '0);
  assign stat.out_busy = out_busy;

  // first deviation from the old mean
  assign xs      = {x_r, {FRAC_W{1'b0}}};
  assign divisor = count_r + COUNT_W'(1);
  assign neg1    = xs < mean_r;
  assign mag1    = neg1 ? (mean_r - xs) : (xs - mean_r);

  // restoring divider step
  assign rem_sh  = {rem_r, quo_r[MEAN_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // mean move and second deviation
  assign mean_new = neg1_r ? (mean_r - quo_r) : (mean_r + quo_r);
  assign neg2     = xs < mean_new_r;
  assign mag2     = neg2 ? (mean_new_r - xs) : (xs - mean_new_r);

  // partial product of the deviation magnitudes
  assign mul_b = cw.mul_hi ? mag2_r[MEAN_W-1:MUL_LO_W] : MUL_B_W'(mag2_r[MUL_LO_W-1:0]);
  assign part  = PART_W'(mag1_r) * PART_W'(mul_b);

  // truncated product and saturating sum
  assign term    = acc_r[PROD_W-1:PROD_SHIFT];
  assign dev_sum = {1'b0, devsum_r} + (DEV_W + 1)'(term);

  // working registers
  always_ff @(posedge clk) begin
    if (stat.accept) begin
      x_r <= in_ch.sample_us;
    end
    if (cw.init) begin
      neg1_r <= neg1;
      mag1_r <= mag1;
      rem_r  <= '0;
      quo_r  <= mag1;
    end
    if (cw.div_step) begin
      rem_r <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quo_r <= {quo_r[MEAN_W-2:0], ge};
    end
    if (cw.mean_upd) begin
      mean_new_r <= mean_new;
    end
    if (cw.dev2) begin
      mag2_r <= mag2;
      skip_r <= (neg1_r != neg2) && (mag1_r != '0) && (mag2 != '0);
    end
    if (cw.mul_lo) begin
      acc_r <= PROD_W'(part);
    end
    if (cw.mul_hi) begin
      acc_r <= acc_r + (PROD_W'(part) << MUL_LO_W);
    end
  end

  // divider step counter and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cw.init) begin
        div_cnt_r <= DIV_CNT_W'(MEAN_W - 1);
        ovf_r     <= full;
      end else if (cw.div_step && (div_cnt_r != '0)) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      if (cw.commit && !skip_r && dev_sum[DEV_W]) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // statistics commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      mean_r   <= '0;
      devsum_r <= '0;
      min_r    <= {SAMPLE_W{1'b1}};
      max_r    <= '0;
    end else if (cw.commit) begin
      count_r <= divisor;
      mean_r  <= mean_new_r;
      if (!skip_r) begin
        devsum_r <= dev_sum[DEV_W] ? {DEV_W{1'b1}} : dev_sum[DEV_W-1:0];
      end
      if (x_r < min_r) begin
        min_r <= x_r;
      end
      if (x_r > max_r) begin
        max_r <= x_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && !out_busy) begin
      out_count_r <= count_r;
      out_mean_r  <= mean_r;
      out_dev_r   <= devsum_r;
      out_min_r   <= min_r;
      out_max_r   <= max_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sample_count    = out_count_r;
  assign out_ch.mean_value      = out_mean_r;
  assign out_ch.squared_dev_sum = out_dev_r;
  assign out_ch.min_sample      = out_min_r;
  assign out_ch.max_sample      = out_max_r;
  assign out_ch.overflow        = out_ovf_r;

endmodule

>>> hw/rtl/rmvmm_useq.sv
// rmvmm_useq: microcode sequencer, program counter and control store lookup
module rmvmm_useq import rmvmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  seq_stat_t  stat,
  output ctrl_word_t cw
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            hold_hit, jmp_hit;

  function automatic logic cond_true(input cond_t c, input seq_stat_t s);
    logic r;
    case (c)
      COND_NEVER:    r = 1'b0;
      COND_ALWAYS:   r = 1'b1;
      COND_NO_INPUT: r = !s.accept;
      COND_FULL:     r = s.full;
      COND_DIV_MORE: r = s.div_more;
      COND_OUT_BUSY: r = s.out_busy;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  // current control word
  assign cw = ucode_rom(pc_r);

  // next step: hold, jump or fall through
  always_comb begin
    hold_hit = cond_true(cw.hold, stat);
    jmp_hit  = cond_true(cw.jmp, stat);
    if (hold_hit) begin
      pc_nxt = pc_r;
    end else if (jmp_hit) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> hw/rtl/rmvmm_checker.sv
// rmvmm_checker: port-level assertions for the running statistics block, with bind
module rmvmm_checker import rmvmm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COUNT_W-1:0]  sample_count,
  input logic [MEAN_W-1:0]   mean_value,
  input logic [SAMPLE_W-1:0] min_sample,
  input logic [SAMPLE_W-1:0] max_sample
);

  // a stalled result stays valid with its count and mean held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_count) && $stable(mean_value))
    else $error("result word changed while stalled");

  // one sample at a time: busy right after an accepted word
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one in flight");

  // a reported result always covers at least one sample
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sample_count != '0 && min_sample <= max_sample)
    else $error("result with empty statistics");

  // mean stays between the extremes
  a_mean_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mean_value[MEAN_W-1:FRAC_W] <= max_sample
                  && mean_value[MEAN_W-1:FRAC_W] >= min_sample)
    else $error("mean outside min/max range");

endmodule

bind running_mean_variance_min_max rmvmm_checker u_rmvmm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sample_count (out_ch.sample_count),
  .mean_value   (out_ch.mean_value),
  .min_sample   (out_ch.min_sample),
  .max_sample   (out_ch.max_sample)
);

>>> verif/running_mean_variance_min_max_test.sv
// running_mean_variance_min_max_test: self-checking bench for the running statistics block
module running_mean_variance_min_max_test;
  import rmvmm_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_WORDS  = 1150;
  localparam int BURST_WORDS   = 700;
  localparam int PHASE_LEN     = 150;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [COUNT_W-1:0]  COUNT_FULL = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;

  // pacing modes, stepped through in blocks of accepted words
  typedef enum logic [1:0] {
    PH_STEADY    = 2'd0,
    PH_SRC_IDLE  = 2'd1,
    PH_SNK_STALL = 2'd2,
    PH_BOTH_IDLE = 2'd3
  } pace_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [MEAN_W-1:0]   mean;
    logic [DEV_W-1:0]    devsum;
    logic [SAMPLE_W-1:0] smin;
    logic [SAMPLE_W-1:0] smax;
    logic                ovf;
  } stats_t;

  localparam logic [SAMPLE_W-1:0] OPENING [20] = '{
    24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
    24'hFFFFFF, 24'h000001, 24'h000002, 24'h000003, 24'hAAAAAA,
    24'h555555, 24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFE,
    24'h000064, 24'h000064, 24'h000064, 24'h123456, 24'hFEDCBA
  };

  logic clk = 1'b0;
  logic rst_n;

  rmvmm_in_if  in_ch ();
  rmvmm_out_if out_ch ();

  running_mean_variance_min_max dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // running statistics as the block should hold them
  logic [COUNT_W-1:0]  tally   = '0;
  logic [MEAN_W-1:0]   avg     = '0;
  logic [DEV_W-1:0]    spread  = '0;
  logic [SAMPLE_W-1:0] lo_seen = SAMPLE_TOP;
  logic [SAMPLE_W-1:0] hi_seen = '0;

  logic [SAMPLE_W-1:0] sample_q [$];
  stats_t              stats_due [$];

  int words_sent    = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int saturations   = 0;
  int clock_ticks   = 0;

  function automatic pace_t current_pace();
    return pace_t'((words_sent / PHASE_LEN) % 4);
  endfunction

  task automatic flag_mismatch(input string what, input logic [DEV_W-1:0] got,
                               input logic [DEV_W-1:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               words_checked, what, got, want);
    end
    mismatches++;
  endtask

  // one welford update per sample, queues the word the block must return
  task automatic fold_sample(input logic [SAMPLE_W-1:0] x);
    logic [MEAN_W-1:0]  xs;
    logic [MEAN_W-1:0]  mag1;
    logic [MEAN_W-1:0]  mag2;
    logic [MEAN_W-1:0]  quot;
    logic [MEAN_W-1:0]  new_mean;
    logic               neg1;
    logic               neg2;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  term;
    logic [DEV_W:0]     sum;
    logic               ovf;
    ovf = 1'b0;
    if (tally == COUNT_FULL) begin
      // count full: sample dropped, state unchanged
      ovf = 1'b1;
    end else begin
      xs       = {x, {FRAC_W{1'b0}}};
      neg1     = xs < avg;
      mag1     = neg1 ? avg - xs : xs - avg;
      tally    = tally + 1'b1;
      quot     = mag1 / tally;
      new_mean = neg1 ? avg - quot : avg + quot;
      neg2     = xs < new_mean;
      mag2     = neg2 ? new_mean - xs : xs - new_mean;
      prod     = mag1 * mag2;
      // opposite signs count as a zero product
      term     = (neg1 == neg2) ? (prod >> PROD_SHIFT) : '0;
      if (term != '0) begin
        sum = {1'b0, spread} + term[DEV_W-1:0];
        if (term[PROD_W-1:DEV_W] != '0 || sum[DEV_W]) begin
          spread = '1;
          ovf    = 1'b1;
        end else begin
          spread = sum[DEV_W-1:0];
        end
      end
      avg = new_mean;
      if (x < lo_seen) lo_seen = x;
      if (x > hi_seen) hi_seen = x;
    end
    if (ovf) saturations++;
    stats_due.push_back('{tally, avg, spread, lo_seen, hi_seen, ovf});
  endtask

  // sample driver
  always @(posedge clk) begin : drive_samples
    logic idle;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fold_sample(in_ch.sample_us);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        case (current_pace())
          PH_SRC_IDLE:  idle = $urandom_range(99) < 87;
          PH_BOTH_IDLE: idle = $urandom_range(99) < 26;
          default:      idle = 1'b0;
        endcase
        if (sample_q.size() != 0 && !idle) begin
          in_ch.valid     <= 1'b1;
          in_ch.sample_us <= sample_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back pressure
  always @(posedge clk) begin : check_results
    stats_t want;
    logic   stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (stats_due.size() == 0) begin
          flag_mismatch("word with nothing pending, count",
                        DEV_W'(out_ch.sample_count), '0);
        end else begin
          want = stats_due.pop_front();
          if (out_ch.sample_count !== want.count)
            flag_mismatch("sample_count", DEV_W'(out_ch.sample_count), DEV_W'(want.count));
          if (out_ch.mean_value !== want.mean)
            flag_mismatch("mean_value", DEV_W'(out_ch.mean_value), DEV_W'(want.mean));
          if (out_ch.squared_dev_sum !== want.devsum)
            flag_mismatch("squared_dev_sum", out_ch.squared_dev_sum, want.devsum);
          if (out_ch.min_sample !== want.smin)
            flag_mismatch("min_sample", DEV_W'(out_ch.min_sample), DEV_W'(want.smin));
          if (out_ch.max_sample !== want.smax)
            flag_mismatch("max_sample", DEV_W'(out_ch.max_sample), DEV_W'(want.smax));
          if (out_ch.overflow !== want.ovf)
            flag_mismatch("overflow", DEV_W'(out_ch.overflow), DEV_W'(want.ovf));
        end
        words_checked++;
      end
      case (current_pace())
        PH_SNK_STALL: stall = $urandom_range(99) < 87;
        PH_BOTH_IDLE: stall = $urandom_range(99) < 26;
        default:      stall = 1'b0;
      endcase
      out_ch.ready <= !stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    clock_ticks++;
    if (clock_ticks > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", clock_ticks);
      $display("running_mean_variance_min_max verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int                  width;
    logic [SAMPLE_W-1:0] x;
    rst_n = 1'b0;

    // extremes, repeats, single bits and alternating patterns
    foreach (OPENING[i]) sample_q.push_back(OPENING[i]);

    // mostly values of random magnitude, some at zero or at or near the top
    repeat (RANDOM_WORDS) begin
      case ($urandom_range(15))
        0: x = $urandom_range(1) ? SAMPLE_TOP : '0;
        1: x = SAMPLE_TOP - SAMPLE_W'($urandom_range(255));
        default: begin
          width = $urandom_range(SAMPLE_W, 1);
          x     = SAMPLE_W'($urandom) & (SAMPLE_TOP >> (SAMPLE_W - width));
        end
      endcase
      sample_q.push_back(x);
    end

    // alternating extremes push the deviation sum into saturation
    for (int i = 0; i < BURST_WORDS; i++) begin
      if (i % 2) sample_q.push_back(SAMPLE_TOP - SAMPLE_W'($urandom_range(15)));
      else sample_q.push_back(SAMPLE_W'($urandom_range(15)));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_q.size() != 0 || in_ch.valid || stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (stats_due.size() != 0) begin
      flag_mismatch("words never delivered", DEV_W'(stats_due.size()), '0);
    end

    $display("%0d samples sent and %0d statistics words checked over four pacing modes",
             words_sent, words_checked);
    $display("%0d words carried the overflow flag, %0d mismatches", saturations,
             mismatches);
    if (mismatches == 0) begin
      $display("running_mean_variance_min_max verification clean");
    end else begin
      $display("running_mean_variance_min_max verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rmvmm_pkg.sv
hw/rtl/rmvmm_in_if.sv
hw/rtl/rmvmm_out_if.sv
hw/rtl/rmvmm_useq.sv
hw/rtl/running_mean_variance_min_max.sv
hw/rtl/rmvmm_checker.sv
verif/running_mean_variance_min_max_test.sv
